### hw/rtl/simple_connected_graph_check_assert.svh
// assertion macros for the simple connected graph check
// used by the top level only, needs clk and rst_n in scope
`ifndef SIMPLE_CONNECTED_GRAPH_CHECK_ASSERT_SVH
`define SIMPLE_CONNECTED_GRAPH_CHECK_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SCG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scg assertion failed");
// next-cycle implication
`define SCG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scg assertion failed");
`else
`define SCG_ASSERT_NOW(label, ante, cons)
`define SCG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/scg_pkg.sv
// shared types, sizes and codes for the simple connected graph check
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scg_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VW           = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int EP_W         = 6;
  localparam int VC_W         = 7;
  localparam int SRC_W        = 6;
  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 1'b1;

  typedef logic [MAX_VERTICES-1:0] row_t;
  typedef logic [VW-1:0]           vidx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_U,
    S_EDGE_V,
    S_EVAL,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic  we;
    vidx_t waddr;
    row_t  wdata;
    vidx_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic load;
    logic value;
  } res_t;

  function automatic vidx_t to_vidx(input logic [EP_W-1:0] ep);
    logic [EP_W+VW-1:0] wide;
    wide = {{VW{1'b0}}, ep};
    return wide[VW-1:0];
  endfunction

  // ones for every vertex below n
  function automatic row_t vertex_mask(input logic [VC_W-1:0] n);
    row_t m;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/scg_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module scg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/scg_ctrl.sv
// sequencer for edge loading and the reachability walk over the adjacency ram
// depends on scg_pkg; the ram itself sits in the top level
`timescale 1ns / 1ps
`default_nettype none

module scg_ctrl
  import scg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_has_edge,
  input  wire logic [EP_W-1:0]   in_edge_u,
  input  wire logic [EP_W-1:0]   in_edge_v,
  input  wire logic              in_is_last,
  input  wire logic [VC_W-1:0]   vertex_count,
  input  wire logic [SRC_W-1:0]  source_vertex,
  input  wire logic              out_free,
  input  wire row_t              ram_rdata,
  output mem_req_t               mem_req,
  output res_t                   res
);

  state_t            state_r, state_nxt;
  vidx_t             u_r, u_nxt;
  vidx_t             v_r, v_nxt;
  logic              last_r, last_nxt;
  logic              failed_r, failed_nxt;
  row_t              reached_r, reached_nxt;
  logic              changed_r, changed_nxt;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              pend_r, pend_nxt;
  vidx_t             pend_idx_r, pend_idx_nxt;
  logic              result_r, result_nxt;
  row_t              row_valid_r, row_valid_nxt;
  logic              rd_valid_r;

  row_t              rd_row;
  logic              edge_bad;
  logic              cfg_bad;
  logic              scan_more;

  // rows never written since the last clear read as zero
  assign rd_row = rd_valid_r ? ram_rdata : '0;

  assign edge_bad = ({1'b0, in_edge_u} >= vertex_count) ||
                    ({1'b0, in_edge_v} >= vertex_count) ||
                    (int'(in_edge_u) >= MAX_VERTICES) ||
                    (int'(in_edge_v) >= MAX_VERTICES) ||
                    (in_edge_u == in_edge_v);

  assign cfg_bad = failed_r || (vertex_count == '0) ||
                   (int'(vertex_count) > MAX_VERTICES) ||
                   ({1'b0, source_vertex} >= vertex_count);

  assign scan_more = int'(scan_idx_r) < int'(vertex_count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      failed_r    <= 1'b0;
      reached_r   <= '0;
      changed_r   <= 1'b0;
      scan_idx_r  <= '0;
      pend_r      <= 1'b0;
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      failed_r    <= failed_nxt;
      reached_r   <= reached_nxt;
      changed_r   <= changed_nxt;
      scan_idx_r  <= scan_idx_nxt;
      pend_r      <= pend_nxt;
      row_valid_r <= row_valid_nxt;
      rd_valid_r  <= row_valid_r[mem_req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    last_r     <= last_nxt;
    pend_idx_r <= pend_idx_nxt;
    result_r   <= result_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    last_nxt      = last_r;
    failed_nxt    = failed_r;
    reached_nxt   = reached_r;
    changed_nxt   = changed_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    result_nxt    = result_r;
    row_valid_nxt = row_valid_r;
    mem_req       = '0;
    in_ready      = 1'b0;
    res           = '0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          u_nxt         = to_vidx(in_edge_u);
          v_nxt         = to_vidx(in_edge_v);
          last_nxt      = in_is_last;
          mem_req.raddr = to_vidx(in_edge_u);
          priority if (in_has_edge && edge_bad) begin
            failed_nxt = 1'b1;
            if (in_is_last) begin
              state_nxt = S_EVAL;
            end
          end else if (in_has_edge) begin
            state_nxt = S_EDGE_U;
          end else if (in_is_last) begin
            state_nxt = S_EVAL;
          end
        end
      end

      S_EDGE_U: begin
        // rows stay symmetric, so row u alone tells a repeat in either order
        if (rd_row[v_r]) begin
          failed_nxt = 1'b1;
          state_nxt  = last_r ? S_EVAL : S_IDLE;
        end else begin
          mem_req.we         = 1'b1;
          mem_req.waddr      = u_r;
          mem_req.wdata      = rd_row | (row_t'(1) << v_r);
          row_valid_nxt[u_r] = 1'b1;
          mem_req.raddr      = v_r;
          state_nxt          = S_EDGE_V;
        end
      end

      S_EDGE_V: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = v_r;
        mem_req.wdata      = rd_row | (row_t'(1) << u_r);
        row_valid_nxt[v_r] = 1'b1;
        state_nxt          = last_r ? S_EVAL : S_IDLE;
      end

      S_EVAL: begin
        if (cfg_bad) begin
          result_nxt = 1'b0;
          state_nxt  = S_RESULT;
        end else begin
          reached_nxt  = row_t'(1);
          changed_nxt  = 1'b0;
          scan_idx_nxt = '0;
          state_nxt    = S_SCAN;
        end
      end

      S_SCAN: begin
        // fold in the row that arrived this cycle if its vertex is reached
        if (pend_r && reached_r[pend_idx_r] && (|(rd_row & ~reached_r))) begin
          reached_nxt = reached_r | rd_row;
          changed_nxt = 1'b1;
        end
        if (scan_more) begin
          mem_req.raddr = scan_idx_r[VW-1:0];
          pend_nxt      = 1'b1;
          pend_idx_nxt  = scan_idx_r[VW-1:0];
          scan_idx_nxt  = scan_idx_r + CNT_W'(1);
        end else if (!pend_r) begin
          // end of a pass: go round again until nothing new is reached
          if (changed_r) begin
            scan_idx_nxt = '0;
            changed_nxt  = 1'b0;
          end else begin
            result_nxt = &(reached_r | ~vertex_mask(vertex_count));
            state_nxt  = S_RESULT;
          end
        end
      end

      S_RESULT: begin
        if (out_free) begin
          res.load      = 1'b1;
          res.value     = result_r;
          row_valid_nxt = '0;
          failed_nxt    = 1'b0;
          reached_nxt   = '0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/simple_connected_graph_check.sv
// Simple connected graph check.
// Input channel (in_valid/in_ready): one beat per undirected edge, fields
// in_has_edge, in_edge_u, in_edge_v and in_is_last. Self-loops, repeated
// edges and endpoints at or above vertex_count fail the graph. The beat
// with in_is_last closes the graph (its edge, if any, is taken first).
// Result channel (out_valid/out_ready): one beat per graph, 1 when the graph
// is simple, the configuration sane and every vertex reachable from vertex 0.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 vertex
// count, 1 source vertex); the user must see that it is only written while
// the block is idle, which the block does not enforce. An edge beat is
// accepted, then each endpoint row gets a read-modify-write in the
// single-read-port adjacency ram; an empty beat is just accepted. The
// closure walks rows 0..n-1 through the ram read port at one row per cycle,
// in passes until one adds nothing (at most n+1), then hands over the result.
// A finished result waits in the output register while new edges are taken;
// a further result holds the walk, and with it the input, until that
// register is free.
// Reset loads vertex count 1, source 0 and an empty graph; row valid bits
// make cleared rows read as zero, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "simple_connected_graph_check_assert.svh"

module simple_connected_graph_check
  import scg_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_has_edge,
  input  wire logic [EP_W-1:0]      in_edge_u,
  input  wire logic [EP_W-1:0]      in_edge_v,
  input  wire logic                 in_is_last,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_simple_and_connected,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic [VC_W-1:0]  vertex_count_r;
  logic [SRC_W-1:0] source_vertex_r;
  logic             out_valid_r;
  logic             out_value_r;
  logic             out_free;
  mem_req_t         mem_req;
  res_t             res;
  row_t             ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r  <= VC_W'(1);
      source_vertex_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT:  vertex_count_r  <= cfg_wdata[VC_W-1:0];
        CFG_SOURCE_VERTEX: source_vertex_r <= cfg_wdata[SRC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // output register parts the result beat from the walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_value_r <= res.value;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_simple_and_connected = out_value_r;

  scg_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (ram_rdata)
  );

  scg_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_has_edge   (in_has_edge),
    .in_edge_u     (in_edge_u),
    .in_edge_v     (in_edge_v),
    .in_is_last    (in_is_last),
    .vertex_count  (vertex_count_r),
    .source_vertex (source_vertex_r),
    .out_free      (out_free),
    .ram_rdata     (ram_rdata),
    .mem_req       (mem_req),
    .res           (res)
  );

  `SCG_ASSERT_NOW(a_load_needs_room, res.load, out_free)
  `SCG_ASSERT_NOW(a_no_load_while_taking, res.load, !in_ready)
  `SCG_ASSERT_NEXT(a_last_stops_input, in_valid && in_ready && in_is_last, !in_ready)
  `SCG_ASSERT_NEXT(a_out_only_from_load, !out_valid_r && !res.load, !out_valid_r)

endmodule

`default_nettype wire

### dv/tb_simple_connected_graph_check.sv
// testbench for simple_connected_graph_check: drives edge beats, predicts the
// pass/fail verdict of each closed graph and compares every result beat
// depends on scg_pkg and the simple_connected_graph_check rtl
`timescale 1ns / 1ps

module tb_simple_connected_graph_check;
  import scg_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 8000000;
  localparam int PHASE_BEATS   = 22;

  typedef struct packed {
    logic [EP_W-1:0] u;
    logic [EP_W-1:0] v;
  } edge_pair_t;

  typedef enum int {
    FLAW_DROP,
    FLAW_DUPLICATE,
    FLAW_SELF_LOOP,
    FLAW_OUT_OF_RANGE,
    FLAW_NOISE
  } flaw_kind_t;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic                 in_has_edge = 1'b0;
  logic [EP_W-1:0]      in_edge_u   = '0;
  logic [EP_W-1:0]      in_edge_v   = '0;
  logic                 in_is_last  = 1'b0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic                 out_simple_and_connected;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]     cfg_wdata   = '0;

  // predictor state
  row_t              adj_rows [MAX_VERTICES];
  bit                graph_broken = 1'b0;
  logic [VC_W-1:0]   vcount       = 7'd1;
  logic [SRC_W-1:0]  src_vertex   = '0;
  bit                expected_verdicts [$];

  edge_pair_t  pending_edges [$];
  int          tx_idle_pct    = 0;
  int          rx_stall_pct   = 0;
  int          beats_sent     = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;

  simple_connected_graph_check dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_has_edge              (in_has_edge),
    .in_edge_u                (in_edge_u),
    .in_edge_v                (in_edge_v),
    .in_is_last               (in_is_last),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_simple_and_connected (out_simple_and_connected),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_wdata                (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    bit want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("result beat %0b with no graph closed",
                                  out_simple_and_connected));
      end else begin
        want = expected_verdicts.pop_front();
        if (out_simple_and_connected !== want)
          report_mismatch($sformatf("simple_and_connected %0b, expected %0b",
                                    out_simple_and_connected, want));
      end
    end
  end

  // takes one accepted beat into the graph and, on the closing beat, works
  // out the verdict and empties the graph
  function automatic void predict_verdict(input bit has_e, input logic [EP_W-1:0] u,
                                          input logic [EP_W-1:0] v, input bit last);
    row_t reached;
    row_t grown;
    bit   verdict;
    if (has_e) begin
      if (u >= vcount || v >= vcount || u == v || adj_rows[u][v])
        graph_broken = 1'b1;
      else begin
        adj_rows[u][v] = 1'b1;
        adj_rows[v][u] = 1'b1;
      end
    end
    if (last) begin
      verdict = 1'b0;
      if (!graph_broken && vcount >= 1 && vcount <= MAX_VERTICES && src_vertex < vcount) begin
        reached    = '0;
        reached[0] = 1'b1;
        // closure only grows from vertices below the count
        for (int s = 0; s < vcount; s++) begin
          grown = reached;
          for (int i = 0; i < vcount; i++)
            if (reached[i]) grown |= adj_rows[i];
          if (grown == reached) break;
          reached = grown;
        end
        verdict = 1'b1;
        for (int i = 0; i < vcount; i++)
          if (!reached[i]) verdict = 1'b0;
      end
      expected_verdicts.insert(expected_verdicts.size(), verdict);
      for (int i = 0; i < MAX_VERTICES; i++) adj_rows[i] = '0;
      graph_broken = 1'b0;
    end
  endfunction

  task automatic send_beat(input bit has_e, input logic [EP_W-1:0] u,
                           input logic [EP_W-1:0] v, input bit last);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_has_edge <= has_e;
    in_edge_u   <= u;
    in_edge_v   <= v;
    in_is_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_verdict(has_e, u, v, last);
    if (has_e || last) beats_sent++;
  endtask

  // sender stops until every verdict is back and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == CFG_VERTEX_COUNT) vcount = data;
    else src_vertex = data[SRC_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pending(input bit empty_close);
    int last_idx;
    last_idx = pending_edges.size() - 1;
    for (int i = 0; i <= last_idx; i++)
      send_beat(1'b1, pending_edges[i].u, pending_edges[i].v,
                !empty_close && i == last_idx);
    if (empty_close || last_idx < 0)
      send_beat(1'b0, EP_W'($urandom_range(0, 63)), EP_W'($urandom_range(0, 63)), 1'b1);
  endtask

  // random spanning tree over the vertices plus a few extra distinct edges,
  // shuffled and randomly oriented
  function automatic void build_graph(input int n, input int extra);
    int         order [MAX_VERTICES];
    row_t       linked [MAX_VERTICES];
    int         gn, j, t, a, b, added;
    edge_pair_t e;
    pending_edges.delete();
    gn    = (n > MAX_VERTICES) ? MAX_VERTICES : n;
    added = 0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      order[i]  = i;
      linked[i] = '0;
    end
    for (int i = gn - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 1; i < gn; i++) begin
      a = order[i];
      b = order[$urandom_range(0, i - 1)];
      linked[a][b] = 1'b1;
      linked[b][a] = 1'b1;
      e.u = a[EP_W-1:0];
      e.v = b[EP_W-1:0];
      pending_edges.insert(pending_edges.size(), e);
    end
    for (int k = 0; gn >= 2 && k < 4 * extra && added < extra; k++) begin
      a = $urandom_range(0, gn - 1);
      b = $urandom_range(0, gn - 1);
      if (a != b && !linked[a][b]) begin
        linked[a][b] = 1'b1;
        linked[b][a] = 1'b1;
        e.u = a[EP_W-1:0];
        e.v = b[EP_W-1:0];
        pending_edges.insert(pending_edges.size(), e);
        added++;
      end
    end
    for (int i = pending_edges.size() - 1; i > 0; i--) begin
      j                = $urandom_range(0, i);
      e                = pending_edges[i];
      pending_edges[i] = pending_edges[j];
      pending_edges[j] = e;
    end
    for (int i = 0; i < pending_edges.size(); i++)
      if ($urandom_range(0, 1))
        {pending_edges[i].u, pending_edges[i].v} = {pending_edges[i].v, pending_edges[i].u};
  endfunction

  function automatic void add_flaw(input int n, input flaw_kind_t kind);
    edge_pair_t e;
    int         pos, hi;
    hi  = (n > MAX_VERTICES) ? MAX_VERTICES : n;
    pos = $urandom_range(0, pending_edges.size());
    e.u = EP_W'($urandom_range(0, 63));
    e.v = EP_W'($urandom_range(0, 63));
    case (kind)
      FLAW_DROP: begin
        if (pending_edges.size() > 0)
          pending_edges.delete($urandom_range(0, pending_edges.size() - 1));
      end
      FLAW_DUPLICATE: begin
        if (pending_edges.size() > 0) begin
          e = pending_edges[$urandom_range(0, pending_edges.size() - 1)];
          if ($urandom_range(0, 1)) {e.u, e.v} = {e.v, e.u};
        end
      end
      FLAW_SELF_LOOP: e.v = e.u;
      FLAW_OUT_OF_RANGE: begin
        if (hi < MAX_VERTICES) e.u = EP_W'($urandom_range(hi, 63));
      end
      default: ;
    endcase
    if (kind != FLAW_DROP) pending_edges.insert(pos, e);
  endfunction

  // reset values: one vertex, source 0
  task automatic test_reset_defaults();
    send_beat(1'b0, 6'd0, 6'd0, 1'b1);
    send_beat(1'b1, 6'd0, 6'd0, 1'b1);
  endtask

  task automatic test_directed_cases();
    wait_idle();
    cfg_write(CFG_VERTEX_COUNT, 7'd4);
    cfg_write(CFG_SOURCE_VERTEX, 7'd3);
    // path, closed by an edge beat
    send_beat(1'b1, 6'd0, 6'd1, 1'b0);
    send_beat(1'b1, 6'd1, 6'd2, 1'b0);
    send_beat(1'b1, 6'd3, 6'd2, 1'b1);
    // repeated edge in the other orientation
    send_beat(1'b1, 6'd0, 6'd1, 1'b0);
    send_beat(1'b1, 6'd1, 6'd0, 1'b0);
    send_beat(1'b1, 6'd2, 6'd3, 1'b1);
    // two components, empty closing beat
    send_beat(1'b1, 6'd0, 6'd3, 1'b0);
    send_beat(1'b1, 6'd1, 6'd2, 1'b0);
    send_beat(1'b0, 6'd63, 6'd63, 1'b1);
    // self-loop at the top of the field range
    send_beat(1'b1, 6'd63, 6'd63, 1'b1);
    // endpoint equal to the vertex count
    send_beat(1'b1, 6'd3, 6'd4, 1'b1);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    cfg_write(CFG_VERTEX_COUNT, 7'd0);
    cfg_write(CFG_SOURCE_VERTEX, 7'd0);
    send_beat(1'b0, 6'd63, 6'd0, 1'b1);
    wait_idle();
    cfg_write(CFG_VERTEX_COUNT, 7'd127);
    send_beat(1'b0, 6'd0, 6'd63, 1'b1);
    wait_idle();
    cfg_write(CFG_VERTEX_COUNT, 7'd2);
    cfg_write(CFG_SOURCE_VERTEX, 7'd2);
    send_beat(1'b1, 6'd1, 6'd0, 1'b1);
    wait_idle();
    // top bit of the data lies outside the source field
    cfg_write(CFG_SOURCE_VERTEX, 7'h41);
    send_beat(1'b1, 6'd0, 6'd1, 1'b1);
  endtask

  // edges are judged against the count in force when they arrive
  task automatic test_check_on_arrival();
    wait_idle();
    cfg_write(CFG_VERTEX_COUNT, 7'd8);
    cfg_write(CFG_SOURCE_VERTEX, 7'd0);
    send_beat(1'b1, 6'd0, 6'd1, 1'b0);
    send_beat(1'b1, 6'd2, 6'd1, 1'b0);
    send_beat(1'b1, 6'd2, 6'd3, 1'b0);
    send_beat(1'b1, 6'd7, 6'd3, 1'b0);
    wait_idle();
    cfg_write(CFG_VERTEX_COUNT, 7'd4);
    send_beat(1'b0, 6'd0, 6'd0, 1'b1);
    send_beat(1'b1, 6'd0, 6'd1, 1'b0);
    send_beat(1'b1, 6'd1, 6'd6, 1'b0);
    wait_idle();
    cfg_write(CFG_VERTEX_COUNT, 7'd8);
    send_beat(1'b1, 6'd1, 6'd2, 1'b1);
  endtask

  task automatic test_full_capacity_graph();
    wait_idle();
    tx_idle_pct  = 15;
    rx_stall_pct = 15;
    cfg_write(CFG_VERTEX_COUNT, 7'd64);
    cfg_write(CFG_SOURCE_VERTEX, 7'd63);
    build_graph(MAX_VERTICES, 0);
    send_pending(1'b0);
    build_graph(MAX_VERTICES, 2);
    add_flaw(MAX_VERTICES, FLAW_DROP);
    send_pending(1'b1);
    build_graph(MAX_VERTICES, 0);
    add_flaw(MAX_VERTICES, FLAW_DUPLICATE);
    send_pending(1'b0);
  endtask

  task automatic test_random_graphs();
    int          n, r, src, hi, phase_start;
    logic [6:0]  src_data;
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      // mostly small graphs, now and then a large or out-of-range count
      r = $urandom_range(0, 9);
      if (r < 7) n = $urandom_range(1, 12);
      else if (r < 9) n = $urandom_range(13, 64);
      else n = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
      hi = (n > MAX_VERTICES) ? MAX_VERTICES : n;
      if (hi >= 1 && $urandom_range(0, 9) < 8) src = $urandom_range(0, hi - 1);
      else src = $urandom_range(0, 63);
      src_data = {1'($urandom_range(0, 1)), src[5:0]};
      cfg_write(CFG_VERTEX_COUNT, n[CFG_W-1:0]);
      cfg_write(CFG_SOURCE_VERTEX, src_data);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          build_graph(n, $urandom_range(0, 3));
        end else if (r < 85) begin
          build_graph(n, $urandom_range(0, 2));
          add_flaw(n, flaw_kind_t'($urandom_range(0, 4)));
        end else begin
          pending_edges.delete();
          repeat ($urandom_range(1, 6)) add_flaw(n, FLAW_NOISE);
        end
        // a beat with neither edge nor close is ignored by the block
        if ($urandom_range(0, 7) == 0)
          send_beat(1'b0, EP_W'($urandom_range(0, 63)), EP_W'($urandom_range(0, 63)), 1'b0);
        send_pending($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 9) == 0) wait_idle();
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_VERTICES; i++) adj_rows[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_register_extremes();
    test_check_on_arrival();
    test_full_capacity_graph();
    test_random_graphs();
    wait_idle();
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
